### design/ils_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg: shared definitions of the indexed list store
// Operation and status codes, datapath select codes, and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int OP_W        = 3;
   localparam int POS_W       = 6;
   localparam int ST_W        = 2;
   localparam int COUNT_OUT_W = 7;

   localparam int CAPACITY_DEF    = 64;
   localparam int VALUE_WIDTH_DEF = 64;

   typedef logic [OP_W-1:0] op_type;
   typedef logic [ST_W-1:0] st_type;

   localparam op_type OP_APPEND = 3'd0;
   localparam op_type OP_INSERT = 3'd1;
   localparam op_type OP_SET    = 3'd2;
   localparam op_type OP_GET    = 3'd3;
   localparam op_type OP_DELETE = 3'd4;
   localparam op_type OP_CLEAR  = 3'd5;

   localparam st_type ST_OK        = 2'd0;
   localparam st_type ST_NOT_FOUND = 2'd1;
   localparam st_type ST_FULL      = 2'd2;

   typedef logic [1:0] sel_type;

   // read address select
   localparam sel_type RD_POS    = 2'd0;
   localparam sel_type RD_IDX_DN = 2'd1;
   localparam sel_type RD_IDX_UP = 2'd2;

   // write address and data select
   localparam sel_type WR_VAL_COUNT = 2'd0;
   localparam sel_type WR_VAL_POS   = 2'd1;
   localparam sel_type WR_RDATA_IDX = 2'd2;

   typedef struct packed {
      logic    req_ready;
      logic    status_load;
      st_type  status_code;
      sel_type rd_sel;
      logic    wr_en;
      sel_type wr_sel;
      logic    idx_load_count;
      logic    idx_load_pos;
      logic    idx_inc;
      logic    idx_dec;
      logic    cnt_inc;
      logic    cnt_dec;
      logic    cnt_clear;
      logic    res_capture;
      logic    rsp_load;
   } cmd_type;

   typedef struct packed {
      logic   req_valid;
      op_type op;
      logic   pos_lt_count;
      logic   pos_le_count;
      logic   full;
      logic   idx_eq_pos;
      logic   idx_last;
      logic   rsp_free;
   } sts_type;

endpackage
`default_nettype wire

### design/ils_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_req_if: request channel
// One request word: operation, list position and the value to store.
// ----------------------------------------------------------------------------
interface ils_req_if
   import ils_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic [POS_W-1:0]       position;
   logic [VALUE_WIDTH-1:0] entry_value;

   modport source (output valid, output operation, output position, output entry_value,
                   input ready);
   modport sink   (input valid, input operation, input position, input entry_value,
                   output ready);
endinterface
`default_nettype wire

### design/ils_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_rsp_if: response channel
// One response word: status, read or displaced value and entry count.
// ----------------------------------------------------------------------------
interface ils_rsp_if
   import ils_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic [ST_W-1:0]        status;
   logic [VALUE_WIDTH-1:0] result_value;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, output status, output result_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input result_value, input entry_count,
                   output ready);
endinterface
`default_nettype wire

### design/ils_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### design/ils_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_ctrl: request sequencer
// Decodes each request and steps the datapath through reads, shifts and
// the response load.
// ----------------------------------------------------------------------------
module ils_ctrl
   import ils_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DISPATCH  = 3'd1;
   localparam logic [2:0] S_READ_WAIT = 3'd2;
   localparam logic [2:0] S_UP_RD     = 3'd3;
   localparam logic [2:0] S_UP_WR     = 3'd4;
   localparam logic [2:0] S_DN_RD     = 3'd5;
   localparam logic [2:0] S_DN_WR     = 3'd6;
   localparam logic [2:0] S_FINISH    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (sts.req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.status_load = 1'b1;
            cmd.status_code = ST_OK;
            state_in        = S_FINISH;
            unique case (sts.op)
               OP_APPEND: begin
                  if (sts.full) begin
                     cmd.status_code = ST_FULL;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_sel  = WR_VAL_COUNT;
                     cmd.cnt_inc = 1'b1;
                  end
               end
               OP_INSERT: begin
                  if (!sts.pos_le_count) begin
                     cmd.status_code = ST_NOT_FOUND;
                  end else if (sts.full) begin
                     cmd.status_code = ST_FULL;
                  end else begin
                     cmd.idx_load_count = 1'b1;
                     state_in           = S_UP_RD;
                  end
               end
               OP_SET, OP_GET, OP_DELETE: begin
                  if (!sts.pos_lt_count) begin
                     cmd.status_code = ST_NOT_FOUND;
                  end else begin
                     cmd.rd_sel = RD_POS;
                     state_in   = S_READ_WAIT;
                  end
               end
               OP_CLEAR: begin
                  cmd.cnt_clear = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_READ_WAIT: begin
            cmd.res_capture = 1'b1;
            state_in        = S_FINISH;
            if (sts.op == OP_SET) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_VAL_POS;
            end else if (sts.op == OP_DELETE) begin
               cmd.idx_load_pos = 1'b1;
               state_in         = S_DN_RD;
            end
         end
         S_UP_RD: begin
            if (sts.idx_eq_pos) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_VAL_POS;
               cmd.cnt_inc = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.rd_sel = RD_IDX_DN;
               state_in   = S_UP_WR;
            end
         end
         S_UP_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_RDATA_IDX;
            cmd.idx_dec = 1'b1;
            state_in    = S_UP_RD;
         end
         S_DN_RD: begin
            if (sts.idx_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.rd_sel = RD_IDX_UP;
               state_in   = S_DN_WR;
            end
         end
         S_DN_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_RDATA_IDX;
            cmd.idx_inc = 1'b1;
            state_in    = S_DN_RD;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

### design/ils_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ils_datapath: list storage and request registers
// Holds the request, entry count, shift index, entry RAM and the response
// output register.
// ----------------------------------------------------------------------------
module ils_datapath
   import ils_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   output sts_type      sts,
   ils_req_if.sink      req,
   ils_rsp_if.source    rsp
);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   op_type                 op_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [ADDR_W-1:0]      idx_ff;
   logic [ADDR_W-1:0]      idx_in;
   st_type                 status_ff;
   logic [VALUE_WIDTH-1:0] res_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   st_type                 rsp_status_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;

   logic [ADDR_W-1:0]      rd_addr;
   logic [ADDR_W-1:0]      wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic [CMP_W-1:0]       pos_ext;
   logic [CMP_W-1:0]       cnt_ext;

   assign pos_ext = CMP_W'(pos_ff);
   assign cnt_ext = CMP_W'(count_ff);

   assign req.ready = cmd.req_ready;

   always_comb begin
      sts.req_valid    = req.valid;
      sts.op           = op_ff;
      sts.pos_lt_count = pos_ext < cnt_ext;
      sts.pos_le_count = pos_ext <= cnt_ext;
      sts.full         = count_ff == CNT_W'(CAPACITY);
      sts.idx_eq_pos   = CMP_W'(idx_ff) == pos_ext;
      sts.idx_last     = (CNT_W'(idx_ff) + CNT_W'(1)) >= count_ff;
      sts.rsp_free     = !rsp_valid_ff || rsp.ready;
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_IDX_DN: rd_addr = idx_ff - ADDR_W'(1);
         RD_IDX_UP: rd_addr = idx_ff + ADDR_W'(1);
         default:   rd_addr = ADDR_W'(pos_ff);
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WR_VAL_COUNT: begin
            wr_addr = ADDR_W'(count_ff);
            wr_data = val_ff;
         end
         WR_VAL_POS: begin
            wr_addr = ADDR_W'(pos_ff);
            wr_data = val_ff;
         end
         default: begin
            wr_addr = idx_ff;
            wr_data = rd_data;
         end
      endcase
   end

   ils_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      priority if (cmd.cnt_clear) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      priority if (cmd.idx_load_count) begin
         idx_in = ADDR_W'(count_ff);
      end else if (cmd.idx_load_pos) begin
         idx_in = ADDR_W'(pos_ff);
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + ADDR_W'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - ADDR_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_comb begin
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (req.valid && cmd.req_ready) begin
         op_ff  <= req.operation;
         pos_ff <= req.position;
         val_ff <= req.entry_value;
      end
      if (cmd.status_load) begin
         status_ff <= cmd.status_code;
         res_ff    <= '0;
      end
      if (cmd.res_capture) begin
         res_ff <= rd_data;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= res_ff;
         rsp_count_ff  <= COUNT_OUT_W'(count_ff);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.entry_count  = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("entry count above capacity");

   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp.ready))
      else $error("response loaded over an untaken word");

   a_wr_addr_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (CMP_W'(wr_addr) < CMP_W'(CAPACITY)))
      else $error("write address past capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.cnt_inc && !cmd.cnt_clear) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("count did not advance on insert");
endmodule
`default_nettype wire

### design/indexed_list_store_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store_core: fixed-capacity ordered list with shift on
// insert and delete
//
// Use: send one request word on req (operation, position, entry_value);
// one response word comes back on rsp (status, result_value, entry_count)
// per request, in order. Both channels move a word when valid and ready
// are high at a rising clock edge.
// Steps from accept to response: append, clear, unused codes and any rejected
// request go from decode straight to the response load; get and set read
// the position first (set then writes it); insert shifts the entries from
// the end down to position p, and delete reads position p and then shifts
// the entries above it down.
// The next request is taken in the cycle after the response is loaded.
// Shifts move one entry at a time, a read state then a write state,
// through the single-write, registered-read entry RAM.
// Reset: synchronous, active high; the list is empty afterwards. Entries
// are not cleared, a fresh list reads only positions it has written.
// Stall: a response that is not taken holds in the output register; the
// block takes the next request meanwhile and holds its result until the
// output register frees up.
// ----------------------------------------------------------------------------
module indexed_list_store_core
   import ils_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   ils_req_if.sink   req,
   ils_rsp_if.source rsp
);
   // command and status bundles between the sequencer and the datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: decode, walk shifts, load response
   ils_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // datapath: request hold, count, shift index, entry RAM, output register
   ils_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts),
      .req   (req),
      .rsp   (rsp)
   );
endmodule
`default_nettype wire
